FILE: rtl/core/pd_filtered_deriv_deadband_assert.svh
// Assertion macros shared by the controller RTL.
// Needs clk and rst_n in the scope of every use; no other dependencies.
`ifndef PD_FILTERED_DERIV_DEADBAND_ASSERT_SVH
`define PD_FILTERED_DERIV_DEADBAND_ASSERT_SVH
`ifndef SYNTHESIS
`define PDFD_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define PDFD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PDFD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PDFD_ASSERT(lbl, cond, msg)
`define PDFD_ASSERT_IMP(lbl, ante, cons, msg)
`define PDFD_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/core/pdfd_pkg.sv
// Package for the filtered-derivative PD controller: widths, register
// indexes, multiplier request/response structs and a rounding helper. No dependencies.
package pdfd_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int FRAC_BITS    = 16;
    localparam int K_BITS       = 16;

    localparam int GAIN_W     = 24;
    localparam int K_W        = K_BITS + 1;
    localparam int DB_W       = 16;
    localparam int HOLD_W     = 8;
    localparam int LIM_W      = 10;
    localparam int DRIVE_W    = 11;
    localparam int DF_W       = 40;
    localparam int ERR_W      = SAMPLE_WIDTH + 1;
    localparam int CMP_W      = (ERR_W > DB_W) ? ERR_W : DB_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = GAIN_W;

    // serial multiplier: multiplier operand consumed one bit per cycle
    localparam int MPLR_W  = (ERR_W + 1 > K_W + 1) ? ERR_W + 1 : K_W + 1;
    localparam int MCAND_W = DF_W + 1;
    localparam int PROD_W  = MCAND_W + MPLR_W;
    localparam int CNT_W   = $clog2(MPLR_W);

    localparam logic [K_W-1:0]   K_ONE     = K_W'(1) << K_BITS;
    localparam logic [LIM_W-1:0] DRIVE_MAX = LIM_W'(1000);

    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_COEFF = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_STEPS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_LIMIT    = 3'd5;

    typedef struct packed {
        logic                      start;
        logic signed [MCAND_W-1:0] mcand;
        logic signed [MPLR_W-1:0]  mplr;
    } mul_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [PROD_W-1:0] product;
    } mul_rsp_t;

    // divide by 2^sh, truncating toward zero
    function automatic logic signed [PROD_W-1:0] trunc_pow2(
        input logic signed [PROD_W-1:0] p,
        input int unsigned              sh
    );
        logic signed [PROD_W-1:0] bias;
        bias = p[PROD_W-1] ? ((PROD_W'(1) << sh) - PROD_W'(1)) : '0;
        return (p + bias) >>> sh;
    endfunction

endpackage

FILE: rtl/core/pdfd_smul.sv
// Radix-2 shift-and-add multiplier, one multiplier bit per cycle.
// Depends on pdfd_pkg and the assertion macro header.
`include "pd_filtered_deriv_deadband_assert.svh"

module pdfd_smul
    import pdfd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MPLR_W - 1);

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic signed [PROD_W-1:0] acc_reg, acc_next;
    logic signed [PROD_W-1:0] mcand_reg, mcand_next;
    logic [MPLR_W-1:0]        mplr_reg, mplr_next;

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        mcand_next = mcand_reg;
        mplr_next  = mplr_reg;
        if (req.start)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            acc_next   = '0;
            mcand_next = PROD_W'(req.mcand);
            mplr_next  = req.mplr;
        end
        else if (busy_reg)
        begin
            // top bit of a two's complement multiplier has negative weight
            if (mplr_reg[0])
            begin
                acc_next = (cnt_reg == CNT_LAST) ? acc_reg - mcand_reg : acc_reg + mcand_reg;
            end
            mcand_next = mcand_reg <<< 1;
            mplr_next  = mplr_reg >> 1;
            cnt_next   = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        mcand_reg <= mcand_next;
        mplr_reg  <= mplr_next;
    end

    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

    `PDFD_ASSERT_IMP(a_no_restart, req.start, !busy_reg, "multiply started while busy")
    `PDFD_ASSERT_NXT(a_done_pulse, done_reg, !done_reg, "done held longer than one cycle")
    `PDFD_ASSERT_IMP(a_done_last, done_reg, $past(cnt_reg) == CNT_LAST && !busy_reg,
                     "done without a full pass over the multiplier")

endmodule

FILE: rtl/core/pd_filtered_deriv_deadband.sv
// Top level of the filtered-derivative PD position controller with settle hold.
// Depends on pdfd_pkg, pdfd_smul and the assertion macro header.
`include "pd_filtered_deriv_deadband_assert.svh"

// One item (measured_pos, target_pos) gives one result (drive_tenths,
// led_toggle). The error is measured - target; the derivative works on the
// measurement and is low-pass filtered, d = kdk*(m - m_prev) + (1-k)*d_prev,
// with kdk = kd*k truncated toward zero. Drive is kp*e + d, scaled to tenths
// (truncated toward zero) and clamped to +-output_limit_tenths (limit capped
// at 1000, k capped at one). A settle counter runs while this and the last
// error both sit inside the deadband; once it reaches hold_steps the drive
// is 0 and led_toggle is 1. Filter and history advance on every item, held
// ones included. All four products go through one serial multiplier that
// takes one bit of its 18-bit operand per cycle, one product after another;
// in_stall is high while an item is in flight, until its result is written
// to the result register. A finished result waits in the output register
// while the next item is accepted. Registers are written through cfg_*
// (always ready); the user must write them only while no item is in flight, as the block does not enforce it.

module pd_filtered_deriv_deadband
    import pdfd_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] measured_pos,
    input  logic signed [SAMPLE_WIDTH-1:0] target_pos,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [DRIVE_W-1:0]    drive_tenths,
    output logic                         led_toggle,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data
);

    localparam int KDK_W = GAIN_W + 1;
    localparam int KDM_W = KDK_W + ERR_W;
    localparam int PE_W  = GAIN_W + ERR_W;
    localparam int U_W   = ((PE_W > DF_W) ? PE_W : DF_W) + 1;
    localparam int U10_W = U_W + 4;

    localparam logic signed [DF_W-1:0] DF_MAX = {1'b0, {(DF_W-1){1'b1}}};
    localparam logic signed [DF_W-1:0] DF_MIN = {1'b1, {(DF_W-1){1'b0}}};

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_KDK   = 7'b0000010,
        S_DM    = 7'b0000100,
        S_DF    = 7'b0001000,
        S_PE    = 7'b0010000,
        S_SCALE = 7'b0100000,
        S_EMIT  = 7'b1000000
    } state_t;

    // configuration
    logic signed [GAIN_W-1:0] prop_gain_reg;
    logic signed [GAIN_W-1:0] deriv_gain_reg;
    logic [K_W-1:0]           filter_coeff_reg;
    logic [DB_W-1:0]          deadband_reg;
    logic [HOLD_W-1:0]        hold_steps_reg;
    logic [LIM_W-1:0]         limit_reg;

    // controller history
    logic signed [ERR_W-1:0]        last_error_reg, last_error_next;
    logic signed [SAMPLE_WIDTH-1:0] last_measured_reg, last_measured_next;
    logic signed [DF_W-1:0]         df_reg, df_next;
    logic [HOLD_W-1:0]              settled_reg, settled_next;

    // per-item working registers
    state_t                   state_reg, state_next;
    logic                     start_reg, start_next;
    logic signed [ERR_W-1:0]  e_reg, e_next;
    logic signed [ERR_W-1:0]  dm_reg, dm_next;
    logic                     held_reg, held_next;
    logic signed [KDK_W-1:0]  kdk_reg, kdk_next;
    logic signed [KDM_W-1:0]  p2_reg, p2_next;
    logic signed [U_W-1:0]    u_reg, u_next;
    logic signed [U10_W-1:0]  u10_reg, u10_next;

    // result register
    logic                      out_valid_reg, out_valid_next;
    logic signed [DRIVE_W-1:0] out_drive_reg, out_drive_next;
    logic                      out_led_reg, out_led_next;

    mul_req_t mul_req;
    mul_rsp_t mul_rsp;

    logic signed [ERR_W-1:0]  e_in;
    logic signed [ERR_W-1:0]  dm_in;
    logic [ERR_W-1:0]         e_abs;
    logic [ERR_W-1:0]         last_abs;
    logic                     band_now;
    logic                     band_last;
    logic [HOLD_W-1:0]        settled_inc;
    logic [K_W-1:0]           k_eff;
    logic [K_W-1:0]           k_comp;
    logic [LIM_W-1:0]         lim_eff;
    logic signed [PROD_W-1:0] prod_trunc;
    logic signed [PROD_W-1:0] d_sum;
    logic signed [PROD_W-1:0] d_sat;
    logic signed [U_W-1:0]    u_sum;
    logic signed [PROD_W-1:0] q_tenths;
    logic signed [PROD_W-1:0] lim_wide;
    logic signed [DRIVE_W-1:0] lim_s;
    logic signed [DRIVE_W-1:0] drive_clamped;
    logic                     accept_in;
    logic                     out_free;

    pdfd_smul u_smul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign accept_in = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // effective register values
    assign k_eff   = (filter_coeff_reg > K_ONE) ? K_ONE : filter_coeff_reg;
    assign k_comp  = K_ONE - k_eff;
    assign lim_eff = (limit_reg > DRIVE_MAX) ? DRIVE_MAX : limit_reg;
    assign lim_s   = DRIVE_W'(lim_eff);

    // error, measurement step and deadband test on the incoming sample
    assign e_in      = ERR_W'(measured_pos) - ERR_W'(target_pos);
    assign dm_in     = ERR_W'(measured_pos) - ERR_W'(last_measured_reg);
    assign e_abs     = e_in[ERR_W-1] ? ERR_W'(-e_in) : ERR_W'(e_in);
    assign last_abs  = last_error_reg[ERR_W-1] ? ERR_W'(-last_error_reg)
                                               : ERR_W'(last_error_reg);
    assign band_now  = CMP_W'(e_abs) <= CMP_W'(deadband_reg);
    assign band_last = CMP_W'(last_abs) <= CMP_W'(deadband_reg);
    assign settled_inc = (settled_reg < hold_steps_reg) ? settled_reg + 1'b1 : settled_reg;

    // multiplier operands follow the state
    always_comb
    begin
        mul_req.start = start_reg;
        case (state_reg)
            S_KDK:
            begin
                mul_req.mcand = MCAND_W'(deriv_gain_reg);
                mul_req.mplr  = MPLR_W'(k_eff);
            end
            S_DM:
            begin
                mul_req.mcand = MCAND_W'(kdk_reg);
                mul_req.mplr  = MPLR_W'(dm_reg);
            end
            S_DF:
            begin
                mul_req.mcand = MCAND_W'(df_reg);
                mul_req.mplr  = MPLR_W'(k_comp);
            end
            S_PE:
            begin
                mul_req.mcand = MCAND_W'(prop_gain_reg);
                mul_req.mplr  = MPLR_W'(e_reg);
            end
            default:
            begin
                mul_req.mcand = '0;
                mul_req.mplr  = '0;
            end
        endcase
    end

    // product post-processing
    assign prod_trunc = trunc_pow2(mul_rsp.product, K_BITS);
    assign d_sum      = PROD_W'(p2_reg) + prod_trunc;
    assign u_sum      = U_W'($signed(mul_rsp.product[PE_W-1:0])) + U_W'(df_reg);

    always_comb
    begin
        if (d_sum > PROD_W'(DF_MAX))
        begin
            d_sat = PROD_W'(DF_MAX);
        end
        else if (d_sum < PROD_W'(DF_MIN))
        begin
            d_sat = PROD_W'(DF_MIN);
        end
        else
        begin
            d_sat = d_sum;
        end
    end

    // tenths: truncate toward zero, then clamp
    assign q_tenths = trunc_pow2(PROD_W'(u10_reg), FRAC_BITS);
    assign lim_wide = PROD_W'(lim_eff);

    always_comb
    begin
        if (q_tenths > lim_wide)
        begin
            drive_clamped = lim_s;
        end
        else if (q_tenths < -lim_wide)
        begin
            drive_clamped = -lim_s;
        end
        else
        begin
            drive_clamped = DRIVE_W'(q_tenths);
        end
    end

    // sequencer
    always_comb
    begin
        state_next         = state_reg;
        start_next         = 1'b0;
        e_next             = e_reg;
        dm_next            = dm_reg;
        held_next          = held_reg;
        kdk_next           = kdk_reg;
        p2_next            = p2_reg;
        u_next             = u_reg;
        u10_next           = u10_reg;
        last_error_next    = last_error_reg;
        last_measured_next = last_measured_reg;
        df_next            = df_reg;
        settled_next       = settled_reg;
        out_drive_next     = out_drive_reg;
        out_led_next       = out_led_reg;
        out_valid_next     = out_valid_reg && out_stall;

        case (state_reg)
            S_IDLE:
            begin
                if (accept_in)
                begin
                    e_next             = e_in;
                    dm_next            = dm_in;
                    last_error_next    = e_in;
                    last_measured_next = measured_pos;
                    if (band_now && band_last)
                    begin
                        settled_next = settled_inc;
                        held_next    = (settled_inc >= hold_steps_reg);
                    end
                    else
                    begin
                        settled_next = '0;
                        held_next    = 1'b0;
                    end
                    state_next = S_KDK;
                    start_next = 1'b1;
                end
            end
            S_KDK:
            begin
                if (mul_rsp.done)
                begin
                    kdk_next   = KDK_W'(prod_trunc);
                    state_next = S_DM;
                    start_next = 1'b1;
                end
            end
            S_DM:
            begin
                if (mul_rsp.done)
                begin
                    p2_next    = KDM_W'(mul_rsp.product);
                    state_next = S_DF;
                    start_next = 1'b1;
                end
            end
            S_DF:
            begin
                if (mul_rsp.done)
                begin
                    df_next    = d_sat[DF_W-1:0];
                    state_next = S_PE;
                    start_next = 1'b1;
                end
            end
            S_PE:
            begin
                if (mul_rsp.done)
                begin
                    u_next     = u_sum;
                    state_next = S_SCALE;
                end
            end
            S_SCALE:
            begin
                // u*10 as u*8 + u*2
                u10_next   = (U10_W'(u_reg) <<< 3) + (U10_W'(u_reg) <<< 1);
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_drive_next = held_reg ? '0 : drive_clamped;
                    out_led_next   = held_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control, history and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            start_reg         <= 1'b0;
            out_valid_reg     <= 1'b0;
            last_error_reg    <= '0;
            last_measured_reg <= '0;
            df_reg            <= '0;
            settled_reg       <= '0;
            prop_gain_reg     <= GAIN_W'(-3932);
            deriv_gain_reg    <= GAIN_W'(-85197);
            filter_coeff_reg  <= K_W'(32768);
            deadband_reg      <= DB_W'(6);
            hold_steps_reg    <= HOLD_W'(50);
            limit_reg         <= LIM_W'(100);
        end
        else
        begin
            state_reg         <= state_next;
            start_reg         <= start_next;
            out_valid_reg     <= out_valid_next;
            last_error_reg    <= last_error_next;
            last_measured_reg <= last_measured_next;
            df_reg            <= df_next;
            settled_reg       <= settled_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_PROP_GAIN:    prop_gain_reg    <= cfg_data[GAIN_W-1:0];
                    CFG_DERIV_GAIN:   deriv_gain_reg   <= cfg_data[GAIN_W-1:0];
                    CFG_FILTER_COEFF: filter_coeff_reg <= cfg_data[K_W-1:0];
                    CFG_DEADBAND:     deadband_reg     <= cfg_data[DB_W-1:0];
                    CFG_HOLD_STEPS:   hold_steps_reg   <= cfg_data[HOLD_W-1:0];
                    CFG_OUT_LIMIT:    limit_reg        <= cfg_data[LIM_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        e_reg         <= e_next;
        dm_reg        <= dm_next;
        held_reg      <= held_next;
        kdk_reg       <= kdk_next;
        p2_reg        <= p2_next;
        u_reg         <= u_next;
        u10_reg       <= u10_next;
        out_drive_reg <= out_drive_next;
        out_led_reg   <= out_led_next;
    end

    assign out_valid    = out_valid_reg;
    assign drive_tenths = out_drive_reg;
    assign led_toggle   = out_led_reg;

    `PDFD_ASSERT_IMP(a_done_in_mul, mul_rsp.done,
                     state_reg == S_KDK || state_reg == S_DM || state_reg == S_DF ||
                     state_reg == S_PE, "product arrived outside a multiply step")
    `PDFD_ASSERT_IMP(a_held_zero, out_valid_reg && out_led_reg, out_drive_reg == '0,
                     "held item with non-zero drive")
    `PDFD_ASSERT_IMP(a_drive_bound, out_valid_reg,
                     out_drive_reg <= lim_s && out_drive_reg >= -lim_s,
                     "drive outside the output limit")

endmodule

FILE: tb/pdfd_checker.sv
// Checker for the filtered-derivative PD controller: tracks the register
// file and controller state, predicts every result and compares.
// Depends on pdfd_pkg.
`timescale 1ns / 100ps

module pdfd_checker
    import pdfd_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] measured_pos,
    input  logic signed [SAMPLE_WIDTH-1:0] target_pos,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic signed [DRIVE_W-1:0]      drive_tenths,
    input  logic                           led_toggle,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [CFG_IDX_W-1:0]           cfg_index,
    input  logic [CFG_DATA_W-1:0]          cfg_data,
    output int                             fail_count,
    output int                             pending
);

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic                      led;
    } drive_result_t;

    localparam longint DERIV_MAX = 64'sd549755813887;
    localparam longint DERIV_MIN = -64'sd549755813888;

    // register copies
    logic signed [GAIN_W-1:0] kp_reg;
    logic signed [GAIN_W-1:0] kd_reg;
    logic [K_W-1:0]           k_reg;
    logic [DB_W-1:0]          db_reg;
    logic [HOLD_W-1:0]        hold_reg;
    logic [LIM_W-1:0]         lim_reg;

    // controller state
    logic signed [ERR_W-1:0]        prev_error;
    logic signed [SAMPLE_WIDTH-1:0] prev_measured;
    logic signed [DF_W-1:0]         deriv_state;
    logic [HOLD_W-1:0]              settle_count;

    drive_result_t drive_expect_q[$];
    drive_result_t want;
    int            reported;

    // one control step: filtered derivative, settle hold, scale and clamp
    function automatic drive_result_t control_step(
        input logic signed [SAMPLE_WIDTH-1:0] m_in,
        input logic signed [SAMPLE_WIDTH-1:0] t_in
    );
        longint        m, t, kp, kd, k, lim, db, e, kdk, d, u, drv, abs_e, abs_prev;
        logic          held;
        drive_result_t r;
        m    = m_in;
        t    = t_in;
        kp   = kp_reg;
        kd   = kd_reg;
        k    = (k_reg > K_ONE) ? longint'(K_ONE) : longint'(k_reg);
        lim  = (lim_reg > DRIVE_MAX) ? longint'(DRIVE_MAX) : longint'(lim_reg);
        db   = longint'(db_reg);
        e    = m - t;
        held = 1'b0;
        drv  = 0;

        kdk = (kd * k) / longint'(K_ONE);
        d   = kdk * (m - longint'(prev_measured))
            + ((longint'(K_ONE) - k) * longint'(deriv_state)) / longint'(K_ONE);
        if (d > DERIV_MAX) d = DERIV_MAX;
        if (d < DERIV_MIN) d = DERIV_MIN;

        abs_e    = (e < 0) ? -e : e;
        abs_prev = (prev_error < 0) ? -longint'(prev_error) : longint'(prev_error);
        if (abs_e <= db && abs_prev <= db) begin
            if (settle_count < hold_reg) settle_count = settle_count + 1'b1;
            if (settle_count >= hold_reg) held = 1'b1;
        end
        else begin
            settle_count = '0;
        end

        if (!held) begin
            u   = kp * e + d;
            drv = (u * 10) / (64'sd1 <<< FRAC_BITS);
            if (drv > lim)  drv = lim;
            if (drv < -lim) drv = -lim;
        end

        prev_error    = e[ERR_W-1:0];
        prev_measured = m_in;
        deriv_state   = d[DF_W-1:0];

        r.drive = drv[DRIVE_W-1:0];
        r.led   = held;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg        = -24'sd3932;
            kd_reg        = -24'sd85197;
            k_reg         = 17'd32768;
            db_reg        = 16'd6;
            hold_reg      = 8'd50;
            lim_reg       = 10'd100;
            prev_error    = '0;
            prev_measured = '0;
            deriv_state   = '0;
            settle_count  = '0;
            drive_expect_q.delete();
            fail_count    = 0;
            pending       = 0;
            reported      = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_PROP_GAIN:    kp_reg   = cfg_data[GAIN_W-1:0];
                    CFG_DERIV_GAIN:   kd_reg   = cfg_data[GAIN_W-1:0];
                    CFG_FILTER_COEFF: k_reg    = cfg_data[K_W-1:0];
                    CFG_DEADBAND:     db_reg   = cfg_data[DB_W-1:0];
                    CFG_HOLD_STEPS:   hold_reg = cfg_data[HOLD_W-1:0];
                    CFG_OUT_LIMIT:    lim_reg  = cfg_data[LIM_W-1:0];
                    default: ;
                endcase
            end

            // results before new items: a result never leaves on its own item's edge
            if (out_valid && !out_stall)
            begin
                if (drive_expect_q.size() == 0)
                begin
                    fail_count++;
                    if (reported < 10)
                        $display("unexpected result: drive %0d led %0b at %0t",
                                 drive_tenths, led_toggle, $realtime);
                    reported++;
                end
                else
                begin
                    want = drive_expect_q.pop_front();
                    if (want.drive !== drive_tenths || want.led !== led_toggle)
                    begin
                        fail_count++;
                        if (reported < 10)
                            $display("mismatch at %0t: drive exp %0d got %0d, led exp %0b got %0b",
                                     $realtime, want.drive, drive_tenths, want.led, led_toggle);
                        reported++;
                    end
                end
            end

            if (in_valid && !in_stall)
                drive_expect_q.push_back(control_step(measured_pos, target_pos));

            pending = drive_expect_q.size();
        end
    end

endmodule

FILE: tb/tb.sv
// Top of the controller testbench: clock, reset, stimulus and verdict.
// Instantiates pd_filtered_deriv_deadband and pdfd_checker; uses pdfd_pkg.
`timescale 1ns / 100ps

module tb
    import pdfd_pkg::*;
();

    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int N_PHASES        = 8;
    localparam int ITEMS_PER_PHASE = 225;
    localparam int QUIET_FROM      = 6;     // phases from here on run without idling

    logic                           clk          = 1'b0;
    logic                           rst_n        = 1'b0;
    logic                           in_valid     = 1'b0;
    logic                           in_stall;
    logic signed [SAMPLE_WIDTH-1:0] measured_pos = '0;
    logic signed [SAMPLE_WIDTH-1:0] target_pos   = '0;
    logic                           out_valid;
    logic                           out_stall    = 1'b0;
    logic signed [DRIVE_W-1:0]      drive_tenths;
    logic                           led_toggle;
    logic                           cfg_valid    = 1'b0;
    logic                           cfg_ready;
    logic [CFG_IDX_W-1:0]           cfg_index    = '0;
    logic [CFG_DATA_W-1:0]          cfg_data     = '0;

    int   fail_count;
    int   pending;
    bit   idle_en     = 1'b1;
    int   stall_left  = 0;
    int   quiet_count = 0;
    logic in_fire_q   = 1'b0;
    logic cfg_fire_q  = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    pd_filtered_deriv_deadband u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .measured_pos (measured_pos),
        .target_pos   (target_pos),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .drive_tenths (drive_tenths),
        .led_toggle   (led_toggle),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    pdfd_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .measured_pos (measured_pos),
        .target_pos   (target_pos),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .drive_tenths (drive_tenths),
        .led_toggle   (led_toggle),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // Handshakes are captured at the rising edge; the drivers look at these
    // flags on the following falling edge, so nothing races within a step.
    always @(posedge clk)
    begin
        in_fire_q  <= in_valid && !in_stall;
        cfg_fire_q <= cfg_valid && cfg_ready;
    end

    // Watchdog: cycles in a row with no item, result or register write.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_count <= 0;
        else if (quiet_count >= WATCHDOG_LIMIT)
        begin
            $display("[pd_filtered_deriv_deadband] ERROR");
            $finish;
        end
        else
            quiet_count <= quiet_count + 1;
    end

    // Receiver back-pressure: stall bursts of random length, started at random while idling is enabled.
    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (idle_en && $urandom_range(0, 7) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 5);
        end
        else
            out_stall <= 1'b0;
    end

    function automatic int to_sample(input int v);
        if (v > 32767)  return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // One item; an optional sender gap first. Valid stays high on return so
    // back-to-back items never drop it within a step.
    task automatic send_sample(input int m, input int t);
        if (idle_en && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        in_valid     <= 1'b1;
        measured_pos <= SAMPLE_WIDTH'(m);
        target_pos   <= SAMPLE_WIDTH'(t);
        do @(negedge clk); while (!in_fire_q);
    endtask

    // Hold off the sender until every outstanding result has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        do @(negedge clk); while (!cfg_fire_q);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        int p, n, run_left, run_kind, tgt, meas, span, cur_db, bits;
        int kp_v, kd_v, k_v, hold_v, lim_v;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // --- directed: reset settings, field extremes and the deadband edge
        send_sample(0, 0);
        send_sample(32767, -32768);
        send_sample(-32768, 32767);
        send_sample(-32768, -32768);
        send_sample(32767, 32767);
        send_sample(6, 0);
        send_sample(0, -6);
        send_sample(7, 0);
        wait_drained();

        // gains at their extremes, filter weight above one, limit above
        // range, and a zero hold count so every settled step is held
        write_reg(CFG_PROP_GAIN, 8388607);
        write_reg(CFG_DERIV_GAIN, -8388608);
        write_reg(CFG_FILTER_COEFF, 131071);
        write_reg(CFG_DEADBAND, 100);
        write_reg(CFG_HOLD_STEPS, 0);
        write_reg(CFG_OUT_LIMIT, 1023);
        send_sample(0, 0);
        send_sample(50, 0);
        send_sample(150, 0);
        send_sample(32767, -32768);
        send_sample(-32768, 32767);
        send_sample(0, 0);
        send_sample(-100, 0);
        send_sample(100, 0);
        wait_drained();

        // zero deadband, short hold: the hold kicks in on the fourth zero-error sample in a row
        write_reg(CFG_PROP_GAIN, 655);
        write_reg(CFG_DERIV_GAIN, 0);
        write_reg(CFG_FILTER_COEFF, 0);
        write_reg(CFG_DEADBAND, 0);
        write_reg(CFG_HOLD_STEPS, 3);
        write_reg(CFG_OUT_LIMIT, 1000);
        send_sample(0, 0);
        send_sample(0, 0);
        send_sample(0, 0);
        send_sample(0, 0);
        send_sample(1, 0);
        wait_drained();

        // --- random phases, each with its own register settings
        meas = 0;
        for (p = 0; p < N_PHASES; p++)
        begin
            // one mid-run stretch and the tail run without any idling
            idle_en = (p != 3) && (p < QUIET_FROM);

            if (p == 0)
            begin
                kp_v = -8388608; kd_v = 8388607; k_v = 0;
                cur_db = 0; hold_v = 1; lim_v = 0;
            end
            else if (p == 1)
            begin
                kp_v = 8388607; kd_v = -8388608; k_v = 65536;
                cur_db = 65535; hold_v = 255; lim_v = 1000;
            end
            else
            begin
                // mostly modest gains so the clamp is not always hit
                bits   = $urandom_range(4, 23);
                kp_v   = int'($urandom_range(0, (1 << bits) - 1)) - (1 << (bits - 1));
                bits   = $urandom_range(4, 23);
                kd_v   = int'($urandom_range(0, (1 << bits) - 1)) - (1 << (bits - 1));
                k_v    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 131071)
                                                     : $urandom_range(0, 65536);
                cur_db = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535)
                                                     : $urandom_range(0, 64);
                hold_v = $urandom_range(0, 12);
                lim_v  = $urandom_range(0, 1023);
            end
            write_reg(CFG_PROP_GAIN, kp_v);
            write_reg(CFG_DERIV_GAIN, kd_v);
            write_reg(CFG_FILTER_COEFF, k_v);
            write_reg(CFG_DEADBAND, cur_db);
            write_reg(CFG_HOLD_STEPS, hold_v);
            write_reg(CFG_OUT_LIMIT, lim_v);

            span     = ((cur_db > 1000) ? 1000 : cur_db) + 1;
            run_left = 0;
            run_kind = 0;
            tgt      = 0;
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // runs: settling near a fixed target (can reach the hold),
                // a drifting ramp, or raw noise over the whole field range
                if (run_left == 0)
                begin
                    run_left = $urandom_range(4, 40);
                    case ($urandom_range(0, 19))
                        0, 1, 2:       run_kind = 2;
                        3, 4, 5, 6, 7: run_kind = 1;
                        default:       run_kind = 0;
                    endcase
                    tgt = int'($urandom_range(0, 65535)) - 32768;
                end
                run_left--;

                case (run_kind)
                    0:
                    begin
                        meas = to_sample(tgt + int'($urandom_range(0, 2 * span)) - span);
                    end
                    1:
                    begin
                        meas = to_sample(meas + int'($urandom_range(0, 600)) - 300);
                        tgt  = to_sample(meas - int'($urandom_range(0, 2 * span)) + span);
                    end
                    default:
                    begin
                        meas = int'($urandom_range(0, 65535)) - 32768;
                        tgt  = int'($urandom_range(0, 65535)) - 32768;
                    end
                endcase

                // sender holds off once per phase until the pipe is empty
                if (n == ITEMS_PER_PHASE / 2)
                    wait_drained();
                send_sample(meas, tgt);
            end
            wait_drained();
        end

        // let any late or stray result show up before the verdict
        repeat (100) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("[pd_filtered_deriv_deadband] OK");
        else
            $display("[pd_filtered_deriv_deadband] ERROR");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/pdfd_pkg.sv
rtl/core/pdfd_smul.sv
rtl/core/pd_filtered_deriv_deadband.sv
tb/pdfd_checker.sv
tb/tb.sv
